// ===== rtl/core/grls_pkg.sv =====
package grls_pkg;

  localparam int unsigned MAX_LINE_DEF    = 1024;
  localparam int unsigned MAX_PENDING_DEF = 8;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned THR_W    = 15;
  localparam int unsigned MARK_W   = 10;

  localparam int unsigned JOB_DEPTH = 4;
  localparam int unsigned LVL_W     = $clog2(JOB_DEPTH + 1);

  localparam int unsigned APB_AW = 2;
  localparam int unsigned APB_DW = 32;
  localparam logic [APB_AW-1:0] ADDR_THR = 2'd0;

endpackage

// ===== rtl/core/grls_ram.sv =====
module grls_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/grls_front.sv =====
module grls_front #(
  parameter int unsigned MAX_LINE    = grls_pkg::MAX_LINE_DEF,
  parameter int unsigned MAX_PENDING = grls_pkg::MAX_PENDING_DEF,
  parameter int unsigned POS_W       = $clog2(MAX_LINE),
  parameter int unsigned CNT_W       = $clog2(MAX_PENDING + 1),
  parameter int unsigned IDX_W       = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic signed [grls_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                          line_end_i,
  input  logic [grls_pkg::THR_W-1:0]    thr_i,
  input  logic [grls_pkg::LVL_W-1:0]    lvl_i,
  output logic                          job_valid_o,
  output logic [POS_W-1:0]              job_start_o,
  output logic [POS_W-1:0]              job_end_o,
  output logic                          job_last_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_CLOSE = 2'b10
  } front_state_e;

  front_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_mid;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] e_q, e_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic [CNT_W-1:0] k_q, k_d;
  logic             rd_vld_q, rd_vld_d;
  logic             rd_last_q, rd_last_d;
  logic [POS_W-1:0] rd_e_q;

  logic signed [grls_pkg::SAMPLE_W:0] g_s, t_s, nt_s;
  logic brk, cls, opn, accept, wr_en, issue;
  logic [grls_pkg::LVL_W:0] inflight;

  assign g_s  = {sample_i[grls_pkg::SAMPLE_W-1], sample_i};
  assign t_s  = {{(grls_pkg::SAMPLE_W + 1 - grls_pkg::THR_W){1'b0}}, thr_i};
  assign nt_s = -t_s;
  assign brk  = g_s > t_s;
  assign cls  = g_s < nt_s;
  assign opn  = !(g_s < t_s);

  assign accept   = push_i && (state_q == ST_IDLE);
  assign full_o   = (state_q != ST_IDLE);
  assign cnt_mid  = (brk || cls) ? '0 : cnt_q;
  assign wr_en    = accept && opn && (cnt_mid < CNT_W'(MAX_PENDING));
  assign inflight = {1'b0, lvl_i} + (grls_pkg::LVL_W + 1)'(rd_vld_q);
  assign issue    = (state_q == ST_CLOSE) &&
                    (inflight < (grls_pkg::LVL_W + 1)'(grls_pkg::JOB_DEPTH));

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    e_d       = e_q;
    n_d       = n_q;
    k_d       = k_q;
    rd_vld_d  = 1'b0;
    rd_last_d = rd_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cnt_d = cnt_mid + CNT_W'(wr_en);
          if (line_end_i) begin
            cnt_d = '0;
            pos_d = '0;
          end else if (pos_q != POS_W'(MAX_LINE - 1)) begin
            pos_d = pos_q + 1'b1;
          end
          if (cls && (cnt_q != '0)) begin
            state_d = ST_CLOSE;
            e_d     = pos_q;
            n_d     = cnt_q - 1'b1;
            k_d     = '0;
          end
        end
      end
      ST_CLOSE: begin
        if (issue) begin
          rd_vld_d  = 1'b1;
          rd_last_d = (k_q == n_q);
          k_d       = k_q + 1'b1;
          if (k_q == n_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      pos_q    <= '0;
      k_q      <= '0;
      n_q      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      k_q      <= k_d;
      n_q      <= n_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e_q       <= e_d;
    rd_last_q <= rd_last_d;
    if (issue) begin
      rd_e_q <= e_q;
    end
  end

  grls_ram #(
    .WIDTH (POS_W),
    .DEPTH (MAX_PENDING),
    .AW    (IDX_W)
  ) u_starts (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_mid[IDX_W-1:0]),
    .wdata_i (pos_q),
    .re_i    (issue),
    .raddr_i (k_q[IDX_W-1:0]),
    .rdata_o (job_start_o)
  );

  assign job_valid_o = rd_vld_q;
  assign job_end_o   = rd_e_q;
  assign job_last_o  = rd_last_q;

endmodule

// ===== rtl/core/grls_fifo.sv =====
module grls_fifo #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = grls_pkg::JOB_DEPTH,
  parameter int unsigned LW    = $clog2(DEPTH + 1),
  parameter int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o,
  output logic [LW-1:0]    level_o
);

  logic [WIDTH-1:0] buf_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [LW-1:0]    lvl_q;
  logic             do_pop;

  assign valid_o = (lvl_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = buf_q[rp_q];
  assign level_o = lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      lvl_q <= lvl_q + LW'(push_i) - LW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/grls_back.sv =====
module grls_back #(
  parameter int unsigned POS_W = $clog2(grls_pkg::MAX_LINE_DEF)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  input  logic [POS_W-1:0]            job_start_i,
  input  logic [POS_W-1:0]            job_end_i,
  input  logic                        job_last_i,
  output logic                        job_pop_o,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [grls_pkg::MARK_W-1:0] mark_o,
  output logic                        last_o
);

  logic                               out_vld_q;
  logic [grls_pkg::MARK_W-1:0]        mark_q;
  logic                               last_q;
  logic                               take;
  logic [POS_W-1:0]                   span, mid;
  logic [POS_W+grls_pkg::MARK_W-1:0]  mid_x;

  assign take  = job_valid_i && (!out_vld_q || pop_i);
  assign span  = (job_end_i >= job_start_i) ? (job_end_i - job_start_i) : '0;
  assign mid   = job_end_i - (span >> 1);
  assign mid_x = (POS_W + grls_pkg::MARK_W)'(mid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (take) begin
      out_vld_q <= 1'b1;
    end else if (pop_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      mark_q <= mid_x[grls_pkg::MARK_W-1:0];
      last_q <= job_last_i;
    end
  end

  assign job_pop_o = take;
  assign empty_o   = !out_vld_q;
  assign mark_o    = mark_q;
  assign last_o    = last_q;

endmodule

// ===== rtl/core/gradient_ridge_line_scanner.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------
// sample   | push / full          | gradient_sample_i, line_end_i
// mark     | empty / pop          | mark_position_o, last_mark_o
// config   | psel/penable/pwrite  | paddr, pwdata, prdata (threshold)
//
// An item that closes no ridge does not stall the input. A closing item with n
// pending starts holds full while they are read from the start RAM, one start
// read per cycle while the four-entry job queue, with reads in flight, has room.
// Marks pass the start RAM read register, the job queue and the output register.
// Reset clears position, start count, queue and output; start RAM is not cleared.
module gradient_ridge_line_scanner #(
  parameter int unsigned MAX_LINE    = grls_pkg::MAX_LINE_DEF,
  parameter int unsigned MAX_PENDING = grls_pkg::MAX_PENDING_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [grls_pkg::SAMPLE_W-1:0] gradient_sample_i,
  input  logic                                line_end_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [grls_pkg::MARK_W-1:0]         mark_position_o,
  output logic                                last_mark_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [grls_pkg::APB_AW-1:0]         paddr,
  input  logic [grls_pkg::APB_DW-1:0]         pwdata,
  output logic [grls_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned POS_W = $clog2(MAX_LINE);
  localparam int unsigned JOB_W = 2 * POS_W + 1;

  logic [grls_pkg::THR_W-1:0] thr_q;
  logic                       cfg_wr;

  logic                       job_valid, job_last, q_valid, q_pop;
  logic [POS_W-1:0]           job_start, job_end;
  logic [JOB_W-1:0]           q_data;
  logic [grls_pkg::LVL_W-1:0] q_level;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == grls_pkg::ADDR_THR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_wr) begin
      thr_q <= pwdata[grls_pkg::THR_W-1:0];
    end
  end

  assign prdata = (paddr == grls_pkg::ADDR_THR) ?
                  {{(grls_pkg::APB_DW - grls_pkg::THR_W){1'b0}}, thr_q} : '0;

  grls_front #(
    .MAX_LINE    (MAX_LINE),
    .MAX_PENDING (MAX_PENDING),
    .POS_W       (POS_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .sample_i    (gradient_sample_i),
    .line_end_i  (line_end_i),
    .thr_i       (thr_q),
    .lvl_i       (q_level),
    .job_valid_o (job_valid),
    .job_start_o (job_start),
    .job_end_o   (job_end),
    .job_last_o  (job_last)
  );

  grls_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (grls_pkg::JOB_DEPTH),
    .LW    (grls_pkg::LVL_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .data_i  ({job_last, job_end, job_start}),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data),
    .level_o (q_level)
  );

  grls_back #(
    .POS_W (POS_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_start_i (q_data[POS_W-1:0]),
    .job_end_i   (q_data[2*POS_W-1:POS_W]),
    .job_last_i  (q_data[JOB_W-1]),
    .job_pop_o   (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .mark_o      (mark_position_o),
    .last_o      (last_mark_o)
  );

endmodule

// ===== rtl/core/grls_checker.sv =====
module grls_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                push,
  input logic                                full,
  input logic signed [grls_pkg::SAMPLE_W-1:0] gradient_sample_i,
  input logic                                empty,
  input logic                                pop,
  input logic [grls_pkg::MARK_W-1:0]         mark_position_o,
  input logic                                last_mark_o,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [grls_pkg::APB_AW-1:0]         paddr,
  input logic [grls_pkg::APB_DW-1:0]         pwdata,
  input logic [grls_pkg::APB_DW-1:0]         prdata
);

  logic [grls_pkg::THR_W-1:0]         thr_q;
  logic                               wr_thr;
  logic signed [grls_pkg::SAMPLE_W:0] g_s, nt_s;

  assign wr_thr = psel && penable && pwrite && (paddr == grls_pkg::ADDR_THR);
  assign g_s    = {gradient_sample_i[grls_pkg::SAMPLE_W-1], gradient_sample_i};
  assign nt_s   = -{{(grls_pkg::SAMPLE_W + 1 - grls_pkg::THR_W){1'b0}}, thr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (wr_thr) begin
      thr_q <= pwdata[grls_pkg::THR_W-1:0];
    end
  end

  a_mark_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(mark_position_o) && $stable(last_mark_o)))
    else $error("waiting mark changed");

  a_thr_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_thr ##1 (paddr == grls_pkg::ADDR_THR) |->
      (prdata[grls_pkg::THR_W-1:0] == $past(pwdata[grls_pkg::THR_W-1:0])))
    else $error("threshold readback mismatch");

  a_prdata_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prdata[grls_pkg::APB_DW-1:grls_pkg::THR_W] == '0)
    else $error("unused readback bits set");

  a_no_close_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && !(g_s < nt_s) && !wr_thr) |=> !full)
    else $error("non-closing item stalled input");

endmodule

bind gradient_ridge_line_scanner grls_checker u_grls_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .push              (push),
  .full              (full),
  .gradient_sample_i (gradient_sample_i),
  .empty             (empty),
  .pop               (pop),
  .mark_position_o   (mark_position_o),
  .last_mark_o       (last_mark_o),
  .psel              (psel),
  .penable           (penable),
  .pwrite            (pwrite),
  .paddr             (paddr),
  .pwdata            (pwdata),
  .prdata            (prdata)
);
